// File: sv/xtea_pkg.sv
// Shared types, constants and round functions for the XTEA-style cipher pipeline.
package xtea_pkg;

    localparam int XTEA_MAX_ROUNDS = 64;
    localparam int RC_W            = 7;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

    localparam logic [31:0]   KEY0_RST    = 32'h0000_1234;
    localparam logic [31:0]   KEY1_RST    = 32'h0000_5678;
    localparam logic [31:0]   KEY2_RST    = 32'h0000_9ABC;
    localparam logic [31:0]   KEY3_RST    = 32'h0000_DEF0;
    localparam logic [RC_W-1:0] ROUNDS_RST = 7'd32;
    localparam logic          DECRYPT_RST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0    = 3'd0,
        REG_KEY1    = 3'd1,
        REG_KEY2    = 3'd2,
        REG_KEY3    = 3'd3,
        REG_ROUNDS  = 3'd4,
        REG_DECRYPT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] in_word1;
        logic [31:0] in_word0;
    } xtea_in_t;

    typedef struct packed {
        logic [31:0] out_word1;
        logic [31:0] out_word0;
    } xtea_out_t;

    typedef logic [3:0][31:0] key_set_t;

    // (x << 4) ^ (x >>> 5)
    function automatic logic [31:0] mix(input logic [31:0] x);
        return {x[27:0], 4'b0000} ^ {{5{x[31]}}, x[31:5]};
    endfunction

    // F(x) + key[sel] + (sum ^ x)
    function automatic logic [31:0] round_term(input logic [31:0] x,
                                               input logic [31:0] sum,
                                               input key_set_t    keys,
                                               input logic [1:0]  sel);
        return mix(x) + keys[sel] + (sum ^ x);
    endfunction

endpackage

// File: sv/xtea_variant_block_cipher_unit.sv
// Top level: fully unrolled XTEA-style cipher, one half-round per pipeline stage.
//
// Usage:
//   Input items (s_valid/s_ready/s_data) carry one 64-bit block as two words.
//   Result items (m_valid/m_ready/m_data) carry the transformed block, in order.
//   cfg_we/cfg_index/cfg_wdata write the key words, round count and mode;
//   write them only while no item is in flight.
// Throughput: one item per cycle, sustained unless m_ready stalls the output.
// Pipeline: the entry register loads at acceptance, followed by one register
//   per half-round and then the output register. Rounds beyond the programmed
//   count pass data through, so latency does not depend on round_count.
// Reset: aresetn low empties the pipeline and restores the default key,
//   round count 32 and decrypt mode.
// Stall: while m_valid waits on m_ready, the pipeline keeps moving as long as
//   its last stage is empty; once it is full, s_ready drops and every stage
//   holds. Nothing is lost or repeated.
module xtea_variant_block_cipher_unit #(
    parameter int MAX_ROUNDS = xtea_pkg::XTEA_MAX_ROUNDS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xtea_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  xtea_pkg::xtea_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output xtea_pkg::xtea_out_t              m_data
);
    import xtea_pkg::*;

    localparam int STAGES = 2 * MAX_ROUNDS;
    localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);

    key_set_t         key_reg;
    logic [RC_W-1:0]  rounds_reg;
    logic             decrypt_reg;

    logic [CNT_W-1:0] eff_rounds;
    logic [31:0]      sum_init;
    logic             run;

    logic             valid_reg [0:STAGES];
    logic [31:0]      v0_reg    [0:STAGES];
    logic [31:0]      v1_reg    [0:STAGES];
    logic [31:0]      sum_reg   [0:STAGES];

    logic             out_valid_reg;
    xtea_out_t        out_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0]  <= KEY0_RST;
            key_reg[1]  <= KEY1_RST;
            key_reg[2]  <= KEY2_RST;
            key_reg[3]  <= KEY3_RST;
            rounds_reg  <= ROUNDS_RST;
            decrypt_reg <= DECRYPT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY0:    key_reg[0]  <= cfg_wdata[31:0];
                REG_KEY1:    key_reg[1]  <= cfg_wdata[31:0];
                REG_KEY2:    key_reg[2]  <= cfg_wdata[31:0];
                REG_KEY3:    key_reg[3]  <= cfg_wdata[31:0];
                REG_ROUNDS:  rounds_reg  <= cfg_wdata[RC_W-1:0];
                REG_DECRYPT: decrypt_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rounds_reg > RC_W'(MAX_ROUNDS)) begin
            eff_rounds = CNT_W'(MAX_ROUNDS);
        end else begin
            eff_rounds = rounds_reg[CNT_W-1:0];
        end
        sum_init = decrypt_reg ? (32'(eff_rounds) * XTEA_DELTA) : 32'd0;
    end

    assign run     = !(valid_reg[STAGES] && out_valid_reg && !m_ready);
    assign s_ready = run;

    // entry register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (run) begin
            valid_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (run && s_valid) begin
            v0_reg[0]  <= s_data.in_word0;
            v1_reg[0]  <= s_data.in_word1;
            sum_reg[0] <= sum_init;
        end
    end

    // half-round stages: even k is the first half of cycle k/2, odd k the second
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int CYC   = k / 2;
        localparam bit FIRST = (k % 2) == 0;

        logic        active;
        logic [31:0] term;
        logic [31:0] v0_next;
        logic [31:0] v1_next;
        logic [31:0] sum_next;

        always_comb begin
            active   = eff_rounds > CNT_W'(CYC);
            v0_next  = v0_reg[k];
            v1_next  = v1_reg[k];
            sum_next = sum_reg[k];
            term     = '0;
            if (active) begin
                if (FIRST) begin
                    if (decrypt_reg) begin
                        term     = round_term(v0_reg[k], sum_reg[k], key_reg,
                                              sum_reg[k][12:11]);
                        v1_next  = v1_reg[k] - term;
                        sum_next = sum_reg[k] - XTEA_DELTA;
                    end else begin
                        term     = round_term(v1_reg[k], sum_reg[k], key_reg,
                                              sum_reg[k][1:0]);
                        v0_next  = v0_reg[k] + term;
                        sum_next = sum_reg[k] + XTEA_DELTA;
                    end
                end else begin
                    if (decrypt_reg) begin
                        term    = round_term(v1_reg[k], sum_reg[k], key_reg,
                                             sum_reg[k][1:0]);
                        v0_next = v0_reg[k] - term;
                    end else begin
                        term    = round_term(v0_reg[k], sum_reg[k], key_reg,
                                             sum_reg[k][12:11]);
                        v1_next = v1_reg[k] + term;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (run) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (run && valid_reg[k]) begin
                v0_reg[k+1]  <= v0_next;
                v1_reg[k+1]  <= v1_next;
                sum_reg[k+1] <= sum_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (valid_reg[STAGES] && (!out_valid_reg || m_ready)) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_reg[STAGES] && (!out_valid_reg || m_ready)) begin
            out_data_reg.out_word0 <= v0_reg[STAGES];
            out_data_reg.out_word1 <= v1_reg[STAGES];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
